// File: rtl/bqf_pkg.sv
`default_nettype none

package bqf_pkg;

	// Default widths of the datapath
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_BITS_DEF   = 32;
	localparam int STATE_BITS_DEF  = 32;

	// Configuration register index width and codes
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF0 = 3'd0,
		REG_FF1 = 3'd1,
		REG_FF2 = 3'd2,
		REG_FB1 = 3'd3,
		REG_FB2 = 3'd4
	} cfg_reg_t;

	// Sequencer: one bit of channel, three bits of phase
	localparam int STEP_W = 4;

	typedef enum logic [2:0] {
		P_X   = 3'd0,
		P_FB1 = 3'd1,
		P_FB2 = 3'd2,
		P_FF1 = 3'd3,
		P_WR  = 3'd4,
		P_FF0 = 3'd5,
		P_ACC = 3'd6,
		P_OUT = 3'd7
	} phase_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	// Coefficient operand of the shared multiplier
	typedef enum logic [2:0] {
		CS_ONE = 3'd0,
		CS_FF0 = 3'd1,
		CS_FF1 = 3'd2,
		CS_FF2 = 3'd3,
		CS_FB1 = 3'd4,
		CS_FB2 = 3'd5
	} coef_sel_t;

	// Data operand of the shared multiplier
	typedef enum logic [1:0] {
		OS_X  = 2'd0,
		OS_W1 = 2'd1,
		OS_W2 = 2'd2,
		OS_W  = 2'd3
	} opnd_sel_t;

	// Accumulator operation
	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef struct packed {
		coef_sel_t coef_sel;
		opnd_sel_t opnd_sel;
		acc_op_t   acc_op;
		logic      chan;
		logic      w_load;
		logic      y_load;
		logic      out_load;
	} seq_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bqf_in_if.sv
`default_nettype none

interface bqf_in_if #(
	parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

// File: rtl/bqf_out_if.sv
`default_nettype none

interface bqf_out_if #(
	parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// File: rtl/stereo_biquad_filter.sv
// Channel  Dir  Payload                Handshake
// din      in   left_in, right_in      valid/ready, taken when both high
// dout     out  left_out, right_out    valid/ready, taken when both high
// cfg      in   cfg_index, cfg_data    cfg_we, written on the clock edge
//
// dout becomes valid after a din transaction once both channels have run through the single
// shared multiplier, which forms six products per channel, followed by rounding and update.
// din is ready only while the sequencer is idle, so a new transaction is not taken until
// the sequence of the previous one has finished.
// A finished result holds until taken; the next item's final step waits while it is held.
// arst_n clears the filter state to zero, ff0 to one and the other taps to zero.
`default_nettype none

module stereo_biquad_filter #(
	parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = bqf_pkg::COEF_BITS_DEF,
	parameter int STATE_BITS  = bqf_pkg::STATE_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [bqf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [COEF_BITS-1:0]            cfg_data,
	bqf_in_if.sink                         din,
	bqf_out_if.source                      dout
);

	localparam int OPND_W = (STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS;
	localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << (COEF_BITS - 4);

	logic signed [COEF_BITS-1:0]   ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
	logic signed [STATE_BITS-1:0]  left_w1_q, left_w2_q, right_w1_q, right_w2_q;
	logic signed [STATE_BITS-1:0]  w_q;
	logic signed [SAMPLE_BITS-1:0] left_x_q, right_x_q;
	logic signed [SAMPLE_BITS-1:0] y_left_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;
	logic signed [COEF_BITS-1:0]   coef;
	logic signed [OPND_W-1:0]      opnd;
	logic signed [STATE_BITS-1:0]  w_sat;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                          out_valid;
	bqf_pkg::seq_ctrl_t            ctrl;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff0_q <= COEF_ONE;
			ff1_q <= '0;
			ff2_q <= '0;
			fb1_q <= '0;
			fb2_q <= '0;
		end else if (cfg_we) begin
			unique case (bqf_pkg::cfg_reg_t'(cfg_index))
				bqf_pkg::REG_FF0: ff0_q <= cfg_data;
				bqf_pkg::REG_FF1: ff1_q <= cfg_data;
				bqf_pkg::REG_FF2: ff2_q <= cfg_data;
				bqf_pkg::REG_FB1: fb1_q <= cfg_data;
				bqf_pkg::REG_FB2: fb2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the input samples of each transaction
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			left_x_q  <= din.left_in;
			right_x_q <= din.right_in;
		end
	end

	// Select the multiplier operands
	always_comb begin
		case (ctrl.coef_sel)
			bqf_pkg::CS_FF0: coef = ff0_q;
			bqf_pkg::CS_FF1: coef = ff1_q;
			bqf_pkg::CS_FF2: coef = ff2_q;
			bqf_pkg::CS_FB1: coef = fb1_q;
			bqf_pkg::CS_FB2: coef = fb2_q;
			default:         coef = COEF_ONE;
		endcase
		case (ctrl.opnd_sel)
			bqf_pkg::OS_X:  opnd = ctrl.chan ? OPND_W'(right_x_q) : OPND_W'(left_x_q);
			bqf_pkg::OS_W1: opnd = ctrl.chan ? OPND_W'(right_w1_q) : OPND_W'(left_w1_q);
			bqf_pkg::OS_W2: opnd = ctrl.chan ? OPND_W'(right_w2_q) : OPND_W'(left_w2_q);
			default:        opnd = OPND_W'(w_q);
		endcase
	end

	bqf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (out_valid),
		.out_ready (dout.ready),
		.ctrl      (ctrl)
	);

	bqf_mac #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS),
		.STATE_BITS  (STATE_BITS),
		.OPND_W      (OPND_W)
	) u_mac (
		.clk    (clk),
		.acc_op (ctrl.acc_op),
		.coef   (coef),
		.opnd   (opnd),
		.w_sat  (w_sat),
		.y_sat  (y_sat)
	);

	// Hold the new delay value, the left result and the output pair
	always_ff @(posedge clk) begin
		if (ctrl.w_load) begin
			w_q <= w_sat;
		end
		if (ctrl.y_load && !ctrl.chan) begin
			y_left_q <= y_sat;
		end
		if (ctrl.out_load) begin
			left_out_q  <= y_left_q;
			right_out_q <= y_sat;
		end
	end

	// Advance the two-deep delay of the channel just finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_w1_q  <= '0;
			left_w2_q  <= '0;
			right_w1_q <= '0;
			right_w2_q <= '0;
		end else if (ctrl.y_load) begin
			if (ctrl.chan) begin
				right_w2_q <= right_w1_q;
				right_w1_q <= w_q;
			end else begin
				left_w2_q <= left_w1_q;
				left_w1_q <= w_q;
			end
		end
	end

	assign dout.valid     = out_valid;
	assign dout.left_out  = left_out_q;
	assign dout.right_out = right_out_q;

endmodule

`default_nettype wire

// File: rtl/bqf_mac.sv
`default_nettype none

module bqf_mac #(
	parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = bqf_pkg::COEF_BITS_DEF,
	parameter int STATE_BITS  = bqf_pkg::STATE_BITS_DEF,
	parameter int OPND_W      = bqf_pkg::STATE_BITS_DEF
) (
	input  wire                           clk,
	input  wire bqf_pkg::acc_op_t         acc_op,
	input  wire signed [COEF_BITS-1:0]    coef,
	input  wire signed [OPND_W-1:0]       opnd,
	output logic signed [STATE_BITS-1:0]  w_sat,
	output logic signed [SAMPLE_BITS-1:0] y_sat
);

	localparam int CF    = COEF_BITS - 4;
	localparam int P_W   = COEF_BITS + OPND_W;
	localparam int ACC_W = P_W + 2;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (CF - 1);
	localparam logic signed [STATE_BITS-1:0] W_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [STATE_BITS-1:0] W_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [P_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sum_r;
	logic signed [ACC_W-1:0] rnd;
	logic [ACC_W-STATE_BITS:0]  w_hi;
	logic [ACC_W-SAMPLE_BITS:0] y_hi;

	// Register each product before it reaches the accumulator
	always_ff @(posedge clk) begin
		prod_s1 <= coef * opnd;
	end

	// Accumulate the registered product
	always_ff @(posedge clk) begin
		case (acc_op)
			bqf_pkg::ACC_LOAD: acc_q <= ACC_W'(prod_s1);
			bqf_pkg::ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			bqf_pkg::ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_s1);
			default:           acc_q <= acc_q;
		endcase
	end

	// Round half up and drop the coefficient fraction bits
	assign sum_r = acc_q + HALF;
	assign rnd   = sum_r >>> CF;

	// Saturate to the state and sample ranges
	assign w_hi = rnd[ACC_W-1:STATE_BITS-1];
	assign y_hi = rnd[ACC_W-1:SAMPLE_BITS-1];

	always_comb begin
		if (w_hi == '0 || w_hi == '1) begin
			w_sat = rnd[STATE_BITS-1:0];
		end else begin
			w_sat = rnd[ACC_W-1] ? W_MIN : W_MAX;
		end
		if (y_hi == '0 || y_hi == '1) begin
			y_sat = rnd[SAMPLE_BITS-1:0];
		end else begin
			y_sat = rnd[ACC_W-1] ? Y_MIN : Y_MAX;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bqf_ctrl.sv
`default_nettype none

module bqf_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output bqf_pkg::seq_ctrl_t  ctrl
);

	localparam logic [bqf_pkg::STEP_W-1:0] STEP_LAST = '1;

	bqf_pkg::state_t             state_q, state_d;
	logic [bqf_pkg::STEP_W-1:0]  step_q, step_d;
	logic                        out_valid_q, out_valid_d;
	logic                        stall;
	logic                        last;
	logic                        advance;
	bqf_pkg::phase_t             phase;

	// State, step counter and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bqf_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	assign phase     = bqf_pkg::phase_t'(step_q[2:0]);
	assign last      = (step_q == STEP_LAST);
	// Hold the final step while the previous result has not been taken
	assign stall     = last && out_valid_q && !out_ready;

	// Next state and datapath controls
	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		in_ready      = 1'b0;
		advance       = 1'b0;
		ctrl.coef_sel = bqf_pkg::CS_ONE;
		ctrl.opnd_sel = bqf_pkg::OS_X;
		ctrl.acc_op   = bqf_pkg::ACC_HOLD;
		ctrl.chan     = step_q[bqf_pkg::STEP_W-1];
		ctrl.w_load   = 1'b0;
		ctrl.y_load   = 1'b0;
		ctrl.out_load = 1'b0;
		unique case (state_q)
			bqf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bqf_pkg::ST_RUN;
				end
			end
			bqf_pkg::ST_RUN: begin
				advance = !stall;
				if (advance) begin
					step_d = step_q + 1'b1;
					if (last) begin
						state_d = bqf_pkg::ST_IDLE;
					end
				end
				unique case (phase)
					bqf_pkg::P_X: begin
						ctrl.coef_sel = bqf_pkg::CS_ONE;
						ctrl.opnd_sel = bqf_pkg::OS_X;
					end
					bqf_pkg::P_FB1: begin
						ctrl.acc_op   = bqf_pkg::ACC_LOAD;
						ctrl.coef_sel = bqf_pkg::CS_FB1;
						ctrl.opnd_sel = bqf_pkg::OS_W1;
					end
					bqf_pkg::P_FB2: begin
						ctrl.acc_op   = bqf_pkg::ACC_SUB;
						ctrl.coef_sel = bqf_pkg::CS_FB2;
						ctrl.opnd_sel = bqf_pkg::OS_W2;
					end
					bqf_pkg::P_FF1: begin
						ctrl.acc_op   = bqf_pkg::ACC_SUB;
						ctrl.coef_sel = bqf_pkg::CS_FF1;
						ctrl.opnd_sel = bqf_pkg::OS_W1;
					end
					bqf_pkg::P_WR: begin
						ctrl.w_load   = 1'b1;
						ctrl.acc_op   = bqf_pkg::ACC_LOAD;
						ctrl.coef_sel = bqf_pkg::CS_FF2;
						ctrl.opnd_sel = bqf_pkg::OS_W2;
					end
					bqf_pkg::P_FF0: begin
						ctrl.acc_op   = bqf_pkg::ACC_ADD;
						ctrl.coef_sel = bqf_pkg::CS_FF0;
						ctrl.opnd_sel = bqf_pkg::OS_W;
					end
					bqf_pkg::P_ACC: begin
						ctrl.acc_op   = bqf_pkg::ACC_ADD;
					end
					bqf_pkg::P_OUT: begin
						ctrl.y_load   = advance;
						ctrl.out_load = advance && ctrl.chan;
					end
					default: begin
						ctrl.acc_op   = bqf_pkg::ACC_HOLD;
					end
				endcase
			end
			default: begin
				state_d = bqf_pkg::ST_IDLE;
			end
		endcase
	end

	// Raise the result flag on the final step, drop it when taken
	always_comb begin
		if (ctrl.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

`ifndef SYNTH
	// A new transaction starts the sequence from its first step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == bqf_pkg::ST_RUN && step_q == '0)
		else $error("sequence did not start at step zero");

	// The counter is parked at zero while idle
	a_park: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 |-> state_q == bqf_pkg::ST_RUN)
		else $error("step counter running while idle");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

	// A result only appears after the last step of the right channel
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == bqf_pkg::ST_RUN && last))
		else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire
